// ===== hw/rtl/sli_pkg.sv =====
package sli_pkg;

  localparam int TW = 16;   // tolerance register
  localparam int QW = 32;   // quotient / crossing point width
  localparam int QDEPTH = 4;

  localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

  function automatic int cap64(input int w);
    return (w > 64) ? 64 : w;
  endfunction

  // determinant / denominator width
  function automatic int zw_of(input int cw);
    return cap64(2 * cw + 3);
  endfunction

  // numerator width
  function automatic int lw_of(input int cw);
    return cap64(3 * cw + 3);
  endfunction

  // rounded numerator width
  function automatic int nw_of(input int cw);
    return (lw_of(cw) < 64) ? lw_of(cw) + 1 : 64;
  endfunction

  // queue word: parallel, hit, px, py, pz
  function automatic int pkt_w_of(input int cw);
    return 2 + 2 * lw_of(cw) + zw_of(cw);
  endfunction

  // round-to-nearest quotient magnitude -> saturated two's complement
  function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] q, input logic ovf,
                                          input logic neg);
    logic [QW-1:0] r;
    if (!neg) begin
      r = (ovf || q[QW-1]) ? SAT_POS : q;
    end else begin
      r = (ovf || (q[QW-1] && (q[QW-2:0] != '0))) ? SAT_NEG : (~q + QW'(1));
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sli_query_if.sv =====
interface sli_query_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;

  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

// ===== hw/rtl/sli_result_if.sv =====
interface sli_result_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               parallel;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;

  modport source (output valid, hit, parallel, cross_x, cross_y, input ready);
  modport sink (input valid, hit, parallel, cross_x, cross_y, output ready);
endinterface

// ===== hw/rtl/segment_line_intersection.sv =====
// Segment / line crossing in homogeneous coordinates.
// query (sink): two segments A-B and C-D, signed fixed point coordinates.
//   A beat is taken when query.valid and query.ready are both high.
// result (source): hit, parallel, and the crossing point in Q24.8,
//   rounded to nearest and saturated; zero point and no hit when parallel.
// tolerance_we / tolerance_wdata: writes the zero threshold (product scale).
//   Write it only while no query is in flight.
// Throughput: one beat per cycle while the output is not stalled by result.ready;
//   the back end uses a 32-stage restoring divider, one quotient bit per stage.
// A four-stage front end forms the lines, determinants and the side test,
//   and feeds a four-entry queue; the back end divides and saturates.
// Reset clears all valid flags, the queue and the tolerance (to zero).
// When result.valid is high and result.ready low the back end holds; the queue
//   then fills, and query.ready falls only once the front end has nowhere to go.
module segment_line_intersection
  import sli_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  sli_query_if.sink             query,
  sli_result_if.source          result,
  input  logic                  tolerance_we,
  input  logic [TW-1:0]         tolerance_wdata
);

  localparam int PKW = pkt_w_of(COORD_WIDTH);

  logic [TW-1:0]  tolerance;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  logic [PKW-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (tolerance_we) begin
      tolerance <= tolerance_wdata;
    end
  end

  sli_front #(
    .CW (COORD_WIDTH),
    .FB (FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .tolerance  (tolerance),
    .query      (query),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sli_queue #(
    .WIDTH (PKW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sli_back #(
    .CW (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

// ===== hw/rtl/sli_front.sv =====
module sli_front
  import sli_pkg::*;
#(
  parameter int CW = 16,
  parameter int FB = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [TW-1:0]             tolerance,
  sli_query_if.sink                 query,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic [pkt_w_of(CW)-1:0]   push_data
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW;
  localparam int C1W = 2 * CW + 1;
  localparam int PDW = 2 * DW;
  localparam int PZF = 2 * CW + 3;
  localparam int XPW = DW + C1W;
  localparam int XFW = XPW + 1;
  localparam int ZW  = zw_of(CW);
  localparam int LW  = lw_of(CW);
  localparam int EW  = (DW + FB > TW) ? DW + FB : TW;

  logic en;
  logic v1, v2, v3, v4;

  // stage 1: differences and point products
  logic signed [DW-1:0] a1, b1, a2, b2, cax, cay, dax, day;
  logic signed [PW-1:0] axby, aybx, cxdy, cydx;
  // stage 2
  logic signed [DW-1:0]  a1_2, b1_2, a2_2, b2_2;
  logic signed [C1W-1:0] c1, c2;
  logic signed [PDW-1:0] pza, pzb, daa, dab, dba, dbb;
  logic                  dcz2, ez2;
  // stage 3
  logic signed [ZW-1:0]  pz3, da3, db3;
  logic signed [XPW-1:0] pbc2, pc1b2, pc1a2, pa1c2;
  logic                  dcz3, ez3;
  // stage 4
  logic signed [LW-1:0]  px4, py4;
  logic signed [ZW-1:0]  pz4;
  logic                  par4, hit4;

  logic [DW-1:0]         m_b2, m_a2, m_b1, m_a1;
  logic signed [PZF-1:0] pz_full, da_full, db_full;
  logic signed [XFW-1:0] px_full, py_full;
  logic signed [ZW-1:0]  tol_z;
  logic                  gtz, ltz, gta, lta, gtb, ltb, za, zb, hit_c;

  assign en          = !v4 || push_ready;
  assign query.ready = en;
  assign push_valid  = v4;
  assign push_data   = {par4, hit4, px4, py4, pz4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= query.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= DW'(query.first_start_y) - DW'(query.first_end_y);
      b1   <= DW'(query.first_end_x) - DW'(query.first_start_x);
      a2   <= DW'(query.second_start_y) - DW'(query.second_end_y);
      b2   <= DW'(query.second_end_x) - DW'(query.second_start_x);
      cax  <= DW'(query.second_start_x) - DW'(query.first_start_x);
      cay  <= DW'(query.second_start_y) - DW'(query.first_start_y);
      dax  <= DW'(query.second_end_x) - DW'(query.first_start_x);
      day  <= DW'(query.second_end_y) - DW'(query.first_start_y);
      axby <= PW'(query.first_start_x) * PW'(query.first_end_y);
      aybx <= PW'(query.first_start_y) * PW'(query.first_end_x);
      cxdy <= PW'(query.second_start_x) * PW'(query.second_end_y);
      cydx <= PW'(query.second_start_y) * PW'(query.second_end_x);
    end
  end

  // |difference| scaled to product scale against tolerance
  assign m_b2 = b2[DW-1] ? DW'(-b2) : DW'(b2);
  assign m_a2 = a2[DW-1] ? DW'(-a2) : DW'(a2);
  assign m_b1 = b1[DW-1] ? DW'(-b1) : DW'(b1);
  assign m_a1 = a1[DW-1] ? DW'(-a1) : DW'(a1);

  // edge vector (ex, ey) of A-B is (b1, -a1)
  always_ff @(posedge clk) begin
    if (en) begin
      a1_2 <= a1;
      b1_2 <= b1;
      a2_2 <= a2;
      b2_2 <= b2;
      c1   <= C1W'(axby) - C1W'(aybx);
      c2   <= C1W'(cxdy) - C1W'(cydx);
      pza  <= PDW'(a1) * PDW'(b2);
      pzb  <= PDW'(b1) * PDW'(a2);
      daa  <= PDW'(cax) * PDW'(-a1);
      dab  <= PDW'(cay) * PDW'(b1);
      dba  <= PDW'(dax) * PDW'(-a1);
      dbb  <= PDW'(day) * PDW'(b1);
      dcz2 <= ((EW'(m_b2) << FB) <= EW'(tolerance)) && ((EW'(m_a2) << FB) <= EW'(tolerance));
      ez2  <= ((EW'(m_b1) << FB) <= EW'(tolerance)) && ((EW'(m_a1) << FB) <= EW'(tolerance));
    end
  end

  assign pz_full = PZF'(pza) - PZF'(pzb);
  assign da_full = PZF'(daa) - PZF'(dab);
  assign db_full = PZF'(dba) - PZF'(dbb);

  always_ff @(posedge clk) begin
    if (en) begin
      pz3   <= pz_full[ZW-1:0];
      da3   <= da_full[ZW-1:0];
      db3   <= db_full[ZW-1:0];
      pbc2  <= XPW'(b1_2) * XPW'(c2);
      pc1b2 <= XPW'(c1) * XPW'(b2_2);
      pc1a2 <= XPW'(c1) * XPW'(a2_2);
      pa1c2 <= XPW'(a1_2) * XPW'(c2);
      dcz3  <= dcz2;
      ez3   <= ez2;
    end
  end

  assign px_full = XFW'(pbc2) - XFW'(pc1b2);
  assign py_full = XFW'(pc1a2) - XFW'(pa1c2);
  assign tol_z   = ZW'(signed'({1'b0, tolerance}));

  // |v| <= tol is the same as -tol <= v <= tol
  assign gtz = pz3 > tol_z;
  assign ltz = pz3 < -tol_z;
  assign gta = da3 > tol_z;
  assign lta = da3 < -tol_z;
  assign gtb = db3 > tol_z;
  assign ltb = db3 < -tol_z;
  assign za  = !gta && !lta;
  assign zb  = !gtb && !ltb;

  always_comb begin
    if ((lta && gtb) || (gta && ltb)) begin
      hit_c = 1'b1;
    end else if (za) begin
      hit_c = zb || dcz3;
    end else if (zb) begin
      hit_c = ez3;
    end else begin
      hit_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px4  <= px_full[LW-1:0];
      py4  <= py_full[LW-1:0];
      pz4  <= pz3;
      par4 <= !gtz && !ltz;
      hit4 <= (gtz || ltz) && hit_c;
    end
  end

endmodule

// ===== hw/rtl/sli_queue.sv =====
module sli_queue
  import sli_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = $clog2(QDEPTH);
  localparam int CNTW = AW + 1;

  logic [WIDTH-1:0] mem [0:QDEPTH-1];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CNTW-1:0]  count;
  logic             push_fire, pop_fire;

  assign push_ready = count != CNTW'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CNTW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CNTW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(QDEPTH))
    else $error("queue occupancy beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push_fire && !pop_fire |=> count == $past(count) + CNTW'(1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop_fire && !push_fire |=> count == $past(count) - CNTW'(1))
    else $error("queue count missed a pop");

endmodule

// ===== hw/rtl/sli_back.sv =====
module sli_back
  import sli_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  logic [pkt_w_of(CW)-1:0] pop_data,
  sli_result_if.source            result
);

  localparam int ZW = zw_of(CW);
  localparam int LW = lw_of(CW);
  localparam int NW = nw_of(CW);
  localparam int RW = (NW > ZW + QW) ? NW : ZW + QW;

  logic en;

  // A: unpacked queue word
  logic                 va, par_a, hit_a;
  logic signed [LW-1:0] px_a, py_a;
  logic signed [ZW-1:0] pz_a;
  // B: magnitudes and signs
  logic                 vb, par_b, hit_b, negx_b, negy_b;
  logic [LW-1:0]        mx_b, my_b;
  logic [ZW-1:0]        md_b;
  // C: rounded numerators
  logic                 vc, par_c, hit_c, negx_c, negy_c;
  logic [NW-1:0]        nx_c, ny_c;
  logic [ZW-1:0]        md_c;

  // divider stages, index 0 is the overflow check
  logic          v    [0:QW];
  logic          par  [0:QW];
  logic          hit  [0:QW];
  logic          negx [0:QW];
  logic          negy [0:QW];
  logic          ovx  [0:QW];
  logic          ovy  [0:QW];
  logic [ZW-1:0] dm   [0:QW];
  logic [RW-1:0] rx   [0:QW];
  logic [RW-1:0] ry   [0:QW];
  logic [QW-1:0] qx   [0:QW];
  logic [QW-1:0] qy   [0:QW];

  assign en        = !result.valid || result.ready;
  assign pop_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      v[0] <= 1'b0;
    end else if (en) begin
      va <= pop_valid;
      vb <= va;
      vc <= vb;
      v[0] <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {par_a, hit_a, px_a, py_a, pz_a} <= pop_data;

      par_b  <= par_a;
      hit_b  <= hit_a;
      mx_b   <= px_a[LW-1] ? LW'(-px_a) : LW'(px_a);
      my_b   <= py_a[LW-1] ? LW'(-py_a) : LW'(py_a);
      md_b   <= pz_a[ZW-1] ? ZW'(-pz_a) : ZW'(pz_a);
      negx_b <= px_a[LW-1] ^ pz_a[ZW-1];
      negy_b <= py_a[LW-1] ^ pz_a[ZW-1];

      // half the divisor added for round to nearest, ties away from zero
      par_c  <= par_b;
      hit_c  <= hit_b;
      negx_c <= negx_b;
      negy_c <= negy_b;
      md_c   <= md_b;
      nx_c   <= NW'(mx_b) + NW'(md_b >> 1);
      ny_c   <= NW'(my_b) + NW'(md_b >> 1);

      par[0]  <= par_c;
      hit[0]  <= hit_c;
      negx[0] <= negx_c;
      negy[0] <= negy_c;
      dm[0]   <= md_c;
      rx[0]   <= RW'(nx_c);
      ry[0]   <= RW'(ny_c);
      qx[0]   <= '0;
      qy[0]   <= '0;
      ovx[0]  <= RW'(nx_c) >= (RW'(md_c) << QW);
      ovy[0]  <= RW'(ny_c) >= (RW'(md_c) << QW);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int K = QW - 1 - i;
    logic [RW-1:0] trial;
    logic          takex, takey;

    assign trial = RW'(dm[i]) << K;
    assign takex = rx[i] >= trial;
    assign takey = ry[i] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        par[i+1]  <= par[i];
        hit[i+1]  <= hit[i];
        negx[i+1] <= negx[i];
        negy[i+1] <= negy[i];
        ovx[i+1]  <= ovx[i];
        ovy[i+1]  <= ovy[i];
        dm[i+1]   <= dm[i];
        rx[i+1]   <= takex ? rx[i] - trial : rx[i];
        ry[i+1]   <= takey ? ry[i] - trial : ry[i];
        qx[i+1]   <= {qx[i][QW-2:0], takex};
        qy[i+1]   <= {qy[i][QW-2:0], takey};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.parallel <= par[QW];
      result.hit      <= hit[QW];
      result.cross_x  <= par[QW] ? '0 : sat_q(qx[QW], ovx[QW], negx[QW]);
      result.cross_y  <= par[QW] ? '0 : sat_q(qy[QW], ovy[QW], negy[QW]);
    end
  end

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.parallel |-> !result.hit && result.cross_x == '0
                                        && result.cross_y == '0)
    else $error("parallel result with a point or a hit");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    en && v[QW] |=> result.valid)
    else $error("finished beat dropped at the output register");

  // data is only meaningful where its stage holds a beat
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v[0]) && $stable(v[QW]) && (!v[0] || $stable(rx[0]))
            && (!v[QW] || $stable(qx[QW])))
    else $error("divider moved while the output was stalled");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import sli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] ax, ay, bx, by, cx, cy, dx, dy;
  } segs_t;

  typedef struct packed {
    logic               hit;
    logic               parallel;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } crossing_t;

  typedef struct packed {
    segs_t     segs;
    logic      typed;
    crossing_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tolerance_we = 1'b0;
  logic [TW-1:0] tolerance_wdata = '0;

  sli_query_if #(.CW(16)) query ();
  sli_result_if result ();

  segment_line_intersection u_dut (
    .clk             (clk),
    .rst             (rst),
    .query           (query),
    .result          (result),
    .tolerance_we    (tolerance_we),
    .tolerance_wdata (tolerance_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  longint    tol_model;
  crossing_t pending_crossings[$];
  row_t      typed_rows[$];
  int        errors;
  logic      q_fire;
  int        quiet_cycles;
  logic      hold_req;
  row_t      rows[$];

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic logic [31:0] div_round(longint num, longint den);
    longint unsigned n, d, q;
    logic neg;
    n = mag(num);
    d = mag(den);
    neg = (num < 0) != (den < 0);
    q = (n + (d >> 1)) / d;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
    end
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return 32'(-q);
  endfunction

  function automatic crossing_t predict_crossing(segs_t s, longint tol);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint a1, b1, c1, a2, b2, c2, px, py, pz, ex, ey, da, db;
    logic za, zb;
    crossing_t r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
    a1 = ay - by; b1 = bx - ax; c1 = ax * by - ay * bx;
    a2 = cy - dy; b2 = dx - cx; c2 = cx * dy - cy * dx;
    px = b1 * c2 - c1 * b2;
    py = c1 * a2 - a1 * c2;
    pz = a1 * b2 - b1 * a2;
    r = '0;
    if (mag(pz) <= tol) begin
      r.parallel = 1'b1;
      return r;
    end
    r.cross_x = div_round(px, pz);
    r.cross_y = div_round(py, pz);
    ex = bx - ax; ey = by - ay;
    da = (cx - ax) * ey - (cy - ay) * ex;
    db = (dx - ax) * ey - (dy - ay) * ex;
    za = mag(da) <= tol;
    zb = mag(db) <= tol;
    if ((da < -tol && db > tol) || (da > tol && db < -tol)) r.hit = 1'b1;
    else if (za) begin
      if (zb) r.hit = 1'b1;
      else if ((mag(dx - cx) << 8) <= tol && (mag(dy - cy) << 8) <= tol) r.hit = 1'b1;
    end else if (zb) begin
      if ((mag(ex) << 8) <= tol && (mag(ey) << 8) <= tol) r.hit = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] near(logic signed [15:0] v, int spread);
    int t;
    t = int'(v) + $urandom_range(2 * spread) - spread;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic segs_t random_segs();
    segs_t s;
    int kind;
    s = segs_t'({$urandom, $urandom, $urandom, $urandom});
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2: begin
        // small coordinates, crossings land inside the range
        s.ax = near(0, 2048); s.ay = near(0, 2048); s.bx = near(0, 2048);
        s.by = near(0, 2048); s.cx = near(0, 2048); s.cy = near(0, 2048);
        s.dx = near(0, 2048); s.dy = near(0, 2048);
      end
      3: begin
        // near parallel: C-D follows B-A with a small skew
        s.ax = near(0, 4096); s.ay = near(0, 4096);
        s.bx = near(s.ax, 1024); s.by = near(s.ay, 1024);
        s.cx = near(0, 4096); s.cy = near(0, 4096);
        s.dx = near(s.cx + (s.bx - s.ax), 2); s.dy = near(s.cy + (s.by - s.ay), 2);
      end
      4: begin
        // C on or next to line A-B
        s.ax = near(0, 1024); s.ay = near(0, 1024);
        s.bx = near(0, 1024); s.by = near(0, 1024);
        s.cx = near(s.ax + (s.bx - s.ax) / 2, 1); s.cy = near(s.ay + (s.by - s.ay) / 2, 1);
      end
      5: begin
        // nearly degenerate second segment
        s.dx = near(s.cx, 1); s.dy = near(s.cy, 1);
      end
      6: begin
        // nearly degenerate first segment
        s.bx = near(s.ax, 1); s.by = near(s.ay, 1);
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic segs_t query_segs();
    return {query.first_start_x, query.first_start_y, query.first_end_x, query.first_end_y,
            query.second_start_x, query.second_start_y, query.second_end_x,
            query.second_end_y};
  endfunction

  // handshakes are judged mid-cycle, where both sides are settled
  always @(negedge clk) begin
    crossing_t got, want;
    row_t tr;
    q_fire = query.valid && query.ready;
    if (!rst) begin
      if (q_fire) pending_crossings.push_back(predict_crossing(query_segs(), tol_model));
      if (result.valid && result.ready) begin
        got = {result.hit, result.parallel, result.cross_x, result.cross_y};
        if (pending_crossings.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = pending_crossings.pop_front();
          if (got.hit !== want.hit)
            $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
          if (got.parallel !== want.parallel)
            $display("%0t: parallel expected %b actual %b", $time, want.parallel, got.parallel);
          if (got.cross_x !== want.cross_x)
            $display("%0t: cross_x expected %h actual %h", $time, want.cross_x, got.cross_x);
          if (got.cross_y !== want.cross_y)
            $display("%0t: cross_y expected %h actual %h", $time, want.cross_y, got.cross_y);
          if (got !== want) errors++;
        end
        if (typed_rows.size() != 0) begin
          tr = typed_rows.pop_front();
          if (tr.typed && got !== tr.want) begin
            $display("%0t: directed row expected %h actual %h", $time, tr.want, got);
            errors++;
          end
        end
      end
      if (q_fire || (result.valid && result.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int mode, left, held;
    result.ready = 1'b0;
    mode = 0;
    left = 0;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result.ready <= 1'b0;
        held++;
        if (held >= 400) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else begin
        if (left == 0) begin
          mode = $urandom_range(3);
          left = $urandom_range(5, 80);
        end
        left--;
        case (mode)
          0: result.ready <= 1'b1;
          1: result.ready <= ($urandom_range(3) != 0);
          2: result.ready <= ($urandom_range(1) != 0);
          default: result.ready <= ($urandom_range(4) == 0);
        endcase
      end
    end
  end

  task automatic wait_idle();
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    query.valid <= 1'b0;
    wait_idle();
    tolerance_we <= 1'b1;
    tolerance_wdata <= v;
    @(posedge clk);
    tolerance_we <= 1'b0;
    tol_model = v;
  endtask

  int burst_left;

  task automatic send_segs(segs_t s, logic typed, crossing_t want);
    row_t tr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(2) != 0) begin
        query.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    tr.segs = s;
    tr.typed = typed;
    tr.want = want;
    query.valid <= 1'b1;
    {query.first_start_x, query.first_start_y, query.first_end_x, query.first_end_y,
     query.second_start_x, query.second_start_y, query.second_end_x,
     query.second_end_y} <= s;
    typed_rows.push_back(tr);
    @(posedge clk);
    while (!q_fire) @(posedge clk);
  endtask

  initial begin
    logic [15:0] tols[6];
    query.valid = 1'b0;
    {query.first_start_x, query.first_start_y, query.first_end_x, query.first_end_y,
     query.second_start_x, query.second_start_y, query.second_end_x,
     query.second_end_y} = '0;
    errors = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    burst_left = 0;
    tol_model = 0;
    q_fire = 1'b0;

    // segments, typed flag, expected {hit, parallel, x, y}
    rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0}});
    rows.push_back('{'{0, 0, 256, 256, 0, 256, 256, 0}, 1'b1,
                     '{1'b1, 1'b0, 32'd128, 32'd128}});
    rows.push_back('{'{0, 0, 256, 0, 128, 256, 128, 512}, 1'b1,
                     '{1'b0, 1'b0, 32'd128, 32'd0}});
    rows.push_back('{'{0, 0, 256, 0, 128, 0, 128, 256}, 1'b0, '0});
    rows.push_back('{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
                     1'b0, '0});
    rows.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b1,
                     '{1'b0, 1'b1, 32'd0, 32'd0}});
    rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
                     1'b1, '{1'b0, 1'b1, 32'd0, 32'd0}});
    rows.push_back('{'{-32768, 0, 32767, 1, -32768, 32767, 32767, 32767}, 1'b0, '0});
    rows.push_back('{'{-32768, 0, 32767, 0, -32768, 1, 32767, 2}, 1'b0, '0});
    rows.push_back('{'{32767, 0, -32768, 0, 32767, 1, -32768, 2}, 1'b0, '0});
    rows.push_back('{'{0, 0, 256, 0, 0, 256, 256, 0}, 1'b0, '0});
    rows.push_back('{'{0, 0, 256, 0, 512, 0, 512, 256}, 1'b0, '0});
    rows.push_back('{'{0, 0, 0, 0, 256, 0, 0, 256}, 1'b0, '0});
    rows.push_back('{'{0, 0, 256, 1, 0, 256, 0, 256}, 1'b0, '0});
    rows.push_back('{'{0, 0, 1, 0, 0, 0, 0, 1}, 1'b0, '0});
    rows.push_back('{'{-1, -1, 1, 1, 1, -1, -1, 1}, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_segs(rows[i].segs, rows[i].typed, rows[i].want);

    tols = '{16'hFFFF, 16'd1, 16'd256, 16'($urandom), 16'd0, 16'd40000};
    foreach (tols[p]) begin
      write_tolerance(tols[p]);
      // directed rows again under the first new threshold, checked by prediction
      if (p == 0) foreach (rows[i]) send_segs(rows[i].segs, 1'b0, '0);
      for (int n = 0; n < 67; n++) begin
        if (p == 1 && n == 10) hold_req = 1'b1;
        if (p == 2 && n == 30) begin
          query.valid <= 1'b0;
          while (pending_crossings.size() != 0) @(posedge clk);
        end
        send_segs(random_segs(), 1'b0, '0);
      end
    end

    query.valid <= 1'b0;
    wait_idle();
    if (errors == 0 && pending_crossings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sli_pkg.sv
hw/rtl/sli_query_if.sv
hw/rtl/sli_result_if.sv
hw/rtl/sli_front.sv
hw/rtl/sli_queue.sv
hw/rtl/sli_back.sv
hw/rtl/segment_line_intersection.sv
tb/testbench.sv
